// File: hdl/float_vector_distance_engine_core_defines.svh
// Assertion macros shared by the distance engine RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef FLOAT_VECTOR_DISTANCE_ENGINE_CORE_DEFINES_SVH
`define FLOAT_VECTOR_DISTANCE_ENGINE_CORE_DEFINES_SVH

// Property that must hold in the same cycle.
`define FVED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a property in the next.
`define FVED_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: hdl/fved_pkg.sv
// Types, constants and IEEE single arithmetic functions for the distance engine.
// No dependencies; used by every module of the block.
`default_nettype none

package fved_pkg;

  // Lane count, fixed by the element ports of the top level
  localparam int LANES      = 4;
  localparam int RED_LEVELS = $clog2(LANES);
  localparam int CNT_W      = 5;

  // Metric codes; unused codes fall back to the inner product
  localparam logic [2:0] MODE_DOT   = 3'd0;
  localparam logic [2:0] MODE_L2SQR = 3'd1;
  localparam logic [2:0] MODE_L1    = 3'd2;
  localparam logic [2:0] MODE_LINF  = 3'd3;
  localparam logic [2:0] MODE_NORM  = 3'd4;

  // Register indexes
  localparam logic REG_METRIC_MODE = 1'b0;

  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] ZERO_BITS = 32'h0000_0000;

  // Datapath widths of the fused adder
  localparam int PROD_W  = 48;
  localparam int GUARD_W = 51;
  localparam int SUM_W   = PROD_W + GUARD_W + 1;

  // Exponent of an operand in adder form: value = man * 2^(ex - 300)
  localparam logic [9:0] TINY_EXP  = 10'd126;
  localparam logic [9:0] C_EXP_OFS = 10'd126;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        sgn;
    logic [9:0]  ex;
    logic [47:0] man;
  } fved_prod_t;

  // Per-lane control for one beat entering a lane
  typedef struct packed {
    logic       take;
    logic       en;
    logic       last;
    logic [2:0] mode;
  } fved_lane_ctl_t;

  // Control that travels with a finished vector
  typedef struct packed {
    logic valid;
    logic is_max;
  } fved_fin_t;

  // Exact product of two singles, tiny products pre-shifted with a sticky jam
  function automatic fved_prod_t fp_prod(input logic [31:0] a, input logic [31:0] b);
    logic [23:0] ma, mb;
    logic [9:0]  ea, eb, pe, sh;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, lost;
    logic [47:0] m, shifted, mask;
    fved_prod_t  r;
    ma     = {|a[30:23], a[22:0]};
    mb     = {|b[30:23], b[22:0]};
    ea     = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
    eb     = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
    a_nan  = (&a[30:23]) && (|a[22:0]);
    b_nan  = (&b[30:23]) && (|b[22:0]);
    a_inf  = (&a[30:23]) && !(|a[22:0]);
    b_inf  = (&b[30:23]) && !(|b[22:0]);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    m      = ma * mb;
    pe     = ea + eb;
    r.nan  = a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
    r.inf  = (a_inf || b_inf) && !r.nan;
    r.sgn  = a[31] ^ b[31];
    if (m == 48'd0) begin
      r.ex  = 10'd0;
      r.man = 48'd0;
    end else if (pe < TINY_EXP) begin
      // far below the subnormal range: fold the low bits into a sticky
      sh = TINY_EXP - pe;
      if (sh >= 10'(PROD_W)) begin
        shifted = 48'd0;
        lost    = 1'b1;
      end else begin
        mask    = (48'd1 << sh) - 48'd1;
        shifted = m >> sh;
        lost    = |(m & mask);
      end
      r.ex  = TINY_EXP;
      r.man = {shifted[47:1], shifted[0] | lost};
    end else begin
      r.ex  = pe;
      r.man = m;
    end
    return r;
  endfunction

  // p + c with one rounding, nearest even, canonical NaN
  function automatic logic [31:0] fp_sum(input fved_prod_t p, input logic [31:0] c);
    logic        c_nan, c_inf, c_zero, p_zero, p_big, sb, ss, rs, normal, rnd, s_lost;
    logic [47:0] mc, mb, ms;
    logic [9:0]  xc, xb, xs, ex_gap, sub_base;
    logic [98:0] s_full, s_part, s_mask;
    logic [99:0] bw, sw, r, n;
    logic [6:0]  lz, sh;
    logic [10:0] e;
    logic [23:0] mant;
    logic [30:0] mag;
    logic [31:0] res;
    c_nan  = (&c[30:23]) && (|c[22:0]);
    c_inf  = (&c[30:23]) && !(|c[22:0]);
    c_zero = (c[30:0] == 31'd0);
    p_zero = (p.man == 48'd0);
    mc     = {|c[30:23], c[22:0], 24'd0};
    xc     = c_zero ? 10'd0
                    : (((c[30:23] == 8'd0) ? 10'd1 : {2'b00, c[30:23]}) + C_EXP_OFS);
    // larger exponent leads, the product on a tie; a zero operand leads only if both are zero
    p_big  = (p.ex >= xc);
    mb     = p_big ? p.man : mc;
    ms     = p_big ? mc : p.man;
    xb     = p_big ? p.ex : xc;
    xs     = p_big ? xc : p.ex;
    sb     = p_big ? p.sgn : c[31];
    ss     = p_big ? c[31] : p.sgn;
    ex_gap = xb - xs;
    s_full = {ms, 51'd0};
    if (ex_gap >= 10'(SUM_W - 1)) begin
      s_mask = 99'd0;
      s_part = 99'd0;
      s_lost = |ms;
    end else begin
      s_mask = (99'd1 << ex_gap) - 99'd1;
      s_part = s_full >> ex_gap;
      s_lost = |(s_full & s_mask);
    end
    bw = {1'b0, mb, 51'd0};
    sw = {1'b0, s_part[98:1], s_part[0] | s_lost};
    // signed magnitude add
    if (sb == ss) begin
      r  = bw + sw;
      rs = sb;
    end else if (bw >= sw) begin
      r  = bw - sw;
      rs = sb;
    end else begin
      r  = sw - bw;
      rs = ss;
    end
    // leading zero count
    lz = 7'(SUM_W - 1);
    for (int i = 0; i < SUM_W; i++) begin
      if (r[i]) lz = 7'(SUM_W - 1 - i);
    end
    // normalize, clamped at the subnormal boundary
    sub_base = xb - TINY_EXP;
    normal   = ({3'b000, lz} <= sub_base);
    sh       = normal ? lz : sub_base[6:0];
    n        = r << sh;
    e        = normal ? ({1'b0, xb} - 11'd125 - {4'b0000, lz}) : 11'd0;
    mant     = n[99:76];
    rnd      = n[75] & ((|n[74:0]) | mant[0]);
    mag      = {e[7:0], mant[22:0]} + {30'd0, rnd};
    if (p.nan || c_nan || (p.inf && c_inf && (p.sgn != c[31]))) begin
      res = QNAN_BITS;
    end else if (p.inf) begin
      res = {p.sgn, 8'hFF, 23'd0};
    end else if (c_inf) begin
      res = {c[31], 8'hFF, 23'd0};
    end else if (p_zero && c_zero) begin
      res = {p.sgn & c[31], 31'd0};
    end else if (r == 100'd0) begin
      res = ZERO_BITS;
    end else if (e >= 11'd255) begin
      res = {rs, 8'hFF, 23'd0};
    end else begin
      res = {rs, mag};
    end
    return res;
  endfunction

  // Max that skips a NaN operand; +0 wins over -0
  function automatic logic [31:0] fp_max(input logic [31:0] a, input logic [31:0] b);
    logic        na, nb;
    logic [31:0] ka, kb, res;
    na = (a[30:0] > 31'h7F80_0000);
    nb = (b[30:0] > 31'h7F80_0000);
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    if (na && nb) begin
      res = QNAN_BITS;
    end else if (na) begin
      res = b;
    end else if (nb) begin
      res = a;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      res = a & b;
    end else if (ka > kb) begin
      res = a;
    end else begin
      res = b;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/fved_lane.sv
// One lane: difference, product and the lane accumulator loop.
// Depends on fved_pkg for the arithmetic functions and control types.
`default_nettype none

module fved_lane import fved_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  fved_lane_ctl_t ctl,
  input  logic [31:0]    x,
  input  logic [31:0]    y,
  output fved_fin_t      fin_ctl,
  output logic [31:0]    fin_bits
);

  logic           s1_valid, s2_valid, s3_valid;
  fved_lane_ctl_t s1_ctl, s2_ctl, s3_ctl;
  logic [31:0]    s1_x, s1_y, s2_x, s2_y, s2_d, s3_absd;
  fved_prod_t     s1_prod, s3_prod, s3_prod_next;
  logic [31:0]    acc, acc_new, lane_val;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= ctl.take;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // stage 1: x as a product with one, ready for x - y
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl  <= ctl;
      s1_x    <= x;
      s1_y    <= y;
      s1_prod <= fp_prod(x, ONE_BITS);
    end
  end

  // stage 2: rounded difference
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl <= s1_ctl;
      s2_x   <= s1_x;
      s2_y   <= s1_y;
      s2_d   <= fp_sum(s1_prod, {~s1_y[31], s1_y[30:0]});
    end
  end

  // stage 3: product feeding the accumulator
  always_comb begin
    unique case (s2_ctl.mode)
      MODE_L2SQR:          s3_prod_next = fp_prod(s2_d, s2_d);
      MODE_L1, MODE_LINF:  s3_prod_next = fp_prod({1'b0, s2_d[30:0]}, ONE_BITS);
      MODE_NORM:           s3_prod_next = fp_prod(s2_x, s2_x);
      default:             s3_prod_next = fp_prod(s2_x, s2_y);
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ctl  <= s2_ctl;
      s3_absd <= {1'b0, s2_d[30:0]};
      s3_prod <= s3_prod_next;
    end
  end

  // stage 4: accumulate combinationally into acc so beats can follow back to back
  assign acc_new  = (s3_ctl.mode == MODE_LINF) ? fp_max(acc, s3_absd) : fp_sum(s3_prod, acc);
  assign lane_val = s3_ctl.en ? acc_new : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= ZERO_BITS;
    end else if (adv && s3_valid) begin
      if (s3_ctl.last) begin
        acc <= ZERO_BITS;
      end else if (s3_ctl.en) begin
        acc <= acc_new;
      end
    end
  end

  // final lane value of a vector
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_ctl <= '0;
    end else if (adv) begin
      fin_ctl.valid  <= s3_valid && s3_ctl.last;
      fin_ctl.is_max <= (s3_ctl.mode == MODE_LINF);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_bits <= lane_val;
    end
  end

endmodule

`default_nettype wire

// File: hdl/fved_reduce.sv
// Pairwise merge tree over the lane results, two register stages per level.
// Depends on fved_pkg for the arithmetic functions and control types.
`default_nettype none

module fved_reduce import fved_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  fved_fin_t   in_ctl,
  input  logic [31:0] in_bits [LANES],
  output fved_fin_t   out_ctl,
  output logic [31:0] out_bits
);

  logic [31:0] lv_bits [RED_LEVELS+1][LANES];
  fved_fin_t   lv_ctl  [RED_LEVELS+1];

  assign lv_ctl[0] = in_ctl;
  for (genvar i = 0; i < LANES; i++) begin : g_in
    assign lv_bits[0][i] = in_bits[i];
  end

  for (genvar k = 0; k < RED_LEVELS; k++) begin : g_lvl
    localparam int NK = (LANES + (2 ** k) - 1) / (2 ** k);
    fved_fin_t a_ctl, b_ctl;

    // control for both stages of this level
    always_ff @(posedge clk) begin
      if (rst) begin
        a_ctl <= '0;
        b_ctl <= '0;
      end else if (adv) begin
        a_ctl <= lv_ctl[k];
        b_ctl <= a_ctl;
      end
    end
    assign lv_ctl[k+1] = b_ctl;

    for (genvar i = 0; i < LANES; i++) begin : g_node
      if (2 * i + 1 < NK) begin : g_pair
        fved_prod_t  a_prod;
        logic [31:0] a_lhs, a_rhs, b_res;
        // left operand as a product, then add or take the max
        always_ff @(posedge clk) begin
          if (adv) begin
            a_prod <= fp_prod(lv_bits[k][2*i], ONE_BITS);
            a_lhs  <= lv_bits[k][2*i];
            a_rhs  <= lv_bits[k][2*i+1];
            b_res  <= a_ctl.is_max ? fp_max(a_lhs, a_rhs) : fp_sum(a_prod, a_rhs);
          end
        end
        assign lv_bits[k+1][i] = b_res;
      end else if (2 * i < NK) begin : g_pass
        logic [31:0] a_lhs, b_res;
        // odd one out waits for its partner level
        always_ff @(posedge clk) begin
          if (adv) begin
            a_lhs <= lv_bits[k][2*i];
            b_res <= a_lhs;
          end
        end
        assign lv_bits[k+1][i] = b_res;
      end else begin : g_none
        assign lv_bits[k+1][i] = ZERO_BITS;
      end
    end
  end

  assign out_ctl  = lv_ctl[RED_LEVELS];
  assign out_bits = lv_bits[RED_LEVELS][0];

endmodule

`default_nettype wire

// File: hdl/float_vector_distance_engine_core.sv
// Streaming fp32 vector distance engine: four lanes, accumulators, merge tree.
// Throughput: one beat per cycle except while stalled.
// Rate is set by the lane accumulator loop, one fused add and round per cycle.
// The whole pipeline stalls only when a result meets a held output beat that is not taken.
// Synchronous reset clears accumulators to +0, metric_mode to 0 and all valid flags.
`default_nettype none
`include "float_vector_distance_engine_core_defines.svh"

module float_vector_distance_engine_core import fved_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] x_elem0,
  input  logic [31:0] x_elem1,
  input  logic [31:0] x_elem2,
  input  logic [31:0] x_elem3,
  input  logic [31:0] y_elem0,
  input  logic [31:0] y_elem1,
  input  logic [31:0] y_elem2,
  input  logic [31:0] y_elem3,
  input  logic [2:0]  valid_count,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] distance_bits
);

  logic [2:0]       metric_mode;
  logic             adv, take;
  logic [31:0]      x_lane [LANES];
  logic [31:0]      y_lane [LANES];
  logic [31:0]      fin_bits [LANES];
  fved_fin_t        fin_ctl [LANES];
  logic [LANES-1:0] lane_fin_valid;
  fved_fin_t        red_ctl;
  logic [31:0]      red_bits;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_METRIC_MODE) ? {29'd0, metric_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_DOT;
    end else if (psel && penable && pwrite && (paddr[2] == REG_METRIC_MODE)) begin
      metric_mode <= pwdata[2:0];
    end
  end

  // advance unless a finished result would collide with a held output beat
  assign adv      = !(red_ctl.valid && out_valid && !out_ready);
  assign in_ready = adv;
  assign take     = in_valid && adv;

  assign x_lane[0] = x_elem0;
  assign x_lane[1] = x_elem1;
  assign x_lane[2] = x_elem2;
  assign x_lane[3] = x_elem3;
  assign y_lane[0] = y_elem0;
  assign y_lane[1] = y_elem1;
  assign y_lane[2] = y_elem2;
  assign y_lane[3] = y_elem3;

  // lanes; counts above the lane count enable every lane
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    fved_lane_ctl_t ctl;
    assign ctl.take = take;
    assign ctl.en   = ({2'b00, valid_count} > CNT_W'(j));
    assign ctl.last = last_item;
    assign ctl.mode = metric_mode;

    fved_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ctl      (ctl),
      .x        (x_lane[j]),
      .y        (y_lane[j]),
      .fin_ctl  (fin_ctl[j]),
      .fin_bits (fin_bits[j])
    );
    assign lane_fin_valid[j] = fin_ctl[j].valid;
  end

  fved_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_ctl   (fin_ctl[0]),
    .in_bits  (fin_bits),
    .out_ctl  (red_ctl),
    .out_bits (red_bits)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && red_ctl.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && red_ctl.valid) begin
      distance_bits <= red_bits;
    end
  end

  // checks
  `FVED_ASSERT(a_lanes_agree, lane_fin_valid == {LANES{lane_fin_valid[0]}}, "lane end flags diverge")
  `FVED_ASSERT_NEXT(a_stall_holds, red_ctl.valid && !in_ready, red_ctl.valid && $stable(red_bits), "pending result lost in stall")
  `FVED_ASSERT(a_stall_cause, in_ready || (out_valid && !out_ready), "stall without a held output beat")

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for float_vector_distance_engine_core.
// Needs fved_pkg and the core RTL; carries its own bit-exact fp32 predictor.
`timescale 1ns / 100ps

module tb;
  import fved_pkg::*;

  localparam logic [2:0]  MODE_ADDR   = 3'(4 * REG_METRIC_MODE);
  localparam logic [2:0]  MODE_SPARE5 = 3'd5;
  localparam logic [2:0]  MODE_SPARE6 = 3'd6;
  localparam logic [2:0]  MODE_SPARE7 = 3'd7;
  localparam logic [31:0] F_TWO  = 32'h4000_0000;
  localparam logic [31:0] F_THREE = 32'h4040_0000;
  localparam logic [31:0] F_FIVE = 32'h40A0_0000;
  localparam logic [31:0] F_NTWO = 32'hC000_0000;
  localparam logic [31:0] F_PINF = 32'h7F80_0000;
  localparam logic [31:0] F_MAXN = 32'h7F7F_FFFF;
  localparam logic [31:0] F_SNAN = 32'h7F80_0001;
  localparam logic [31:0] F_NZERO = 32'h8000_0000;
  localparam logic [31:0] F_TINY = 32'h0000_0001;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;

  typedef struct {
    logic [31:0] xs[4];
    logic [31:0] ys[4];
    logic [2:0]  cnt;
    logic        last;
  } vec_beat_t;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] xv, yv;
    logic [2:0]  cnt;
    logic        last;
    bit          typed;
    logic [31:0] want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0, in_ready;
  logic [31:0] x_elem0 = '0, x_elem1 = '0, x_elem2 = '0, x_elem3 = '0;
  logic [31:0] y_elem0 = '0, y_elem1 = '0, y_elem2 = '0, y_elem3 = '0;
  logic [2:0]  valid_count = 3'd1;
  logic        last_item = 1'b0;
  logic        out_valid, out_ready = 1'b0;
  logic [31:0] distance_bits;

  // predictor state
  logic [31:0] lane_acc[4];
  logic [2:0]  cur_mode;
  logic [31:0] dist_q[$];

  int errors = 0, beats_in = 0, dists_out = 0, burst_left = 0;
  bit hold_req = 1'b0;
  bit holding;

  always #1 clk = ~clk;

  float_vector_distance_engine_core u_dut (.*);

  // Round sign * mag * 2^er to single, nearest even
  function automatic logic [31:0] round_to_single(bit sgn, logic [199:0] mag, int er);
    int p, e_top, lsb, sh;
    logic [199:0] keep;
    bit g, st;
    p = -1;
    for (int i = 0; i < 200; i++) if (mag[i]) p = i;
    e_top = p + er;
    lsb = (e_top - 23 > -149) ? e_top - 23 : -149;
    sh = lsb - er;
    g = 1'b0;
    st = 1'b0;
    if (sh <= 0) begin
      keep = mag << (-sh);
    end else if (sh > 200) begin
      keep = '0;
      st = |mag;
    end else begin
      keep = mag >> sh;
      g = mag[sh-1];
      st = |(mag & ((200'd1 << (sh - 1)) - 200'd1));
    end
    if (g && (st || keep[0])) keep = keep + 200'd1;
    if (keep >= (200'd1 << 24)) begin
      keep = keep >> 1;
      lsb++;
    end
    if (keep < (200'd1 << 23)) return {sgn, 8'd0, keep[22:0]};
    if (lsb + 150 >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, 8'(lsb + 150), keep[22:0]};
  endfunction

  // a * b + c, one rounding
  function automatic logic [31:0] fused_mac(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [31:0] v[3];
    bit nan[3], inf[3], zer[3];
    logic [23:0] m[3];
    int ex[3];
    logic [199:0] h, l, mag;
    int eh, el, d, k, sh;
    bit ps, hs, ls, st;
    v[0] = a; v[1] = b; v[2] = c;
    for (int i = 0; i < 3; i++) begin
      nan[i] = (v[i][30:0] > 31'h7F80_0000);
      inf[i] = (v[i][30:0] == 31'h7F80_0000);
      zer[i] = (v[i][30:0] == 31'd0);
      m[i]   = {v[i][30:23] != 8'd0, v[i][22:0]};
      ex[i]  = ((v[i][30:23] == 8'd0) ? 1 : int'(v[i][30:23])) - 150;
    end
    ps = a[31] ^ b[31];
    if (nan[0] || nan[1] || nan[2]) return QNAN_BITS;
    if ((inf[0] || inf[1]) && (zer[0] || zer[1])) return QNAN_BITS;
    if (inf[0] || inf[1]) begin
      if (inf[2] && c[31] != ps) return QNAN_BITS;
      return {ps, 8'hFF, 23'd0};
    end
    if (inf[2]) return c;
    if ((zer[0] || zer[1]) && zer[2]) return {ps & c[31], 31'd0};
    if (zer[0] || zer[1]) return c;
    h = 200'(m[0]) * 200'(m[1]);
    eh = ex[0] + ex[1];
    if (zer[2]) return round_to_single(ps, h, eh);
    hs = ps;
    l = 200'(m[2]);
    el = ex[2];
    ls = c[31];
    if (el > eh) begin
      mag = h; h = l; l = mag;
      d = eh; eh = el; el = d;
      st = hs; hs = ls; ls = st;
    end
    // align the term with the lower LSB exponent, jam far bits into a sticky
    d = eh - el;
    k = (d > 120) ? 120 : d;
    h = h << k;
    sh = d - k;
    if (sh > 0) begin
      if (sh >= 200) begin
        st = |l;
        l = '0;
      end else begin
        st = |(l & ((200'd1 << sh) - 200'd1));
        l = l >> sh;
      end
      l[0] = l[0] | st;
    end
    if (hs == ls) return round_to_single(hs, h + l, eh - k);
    if (h > l) return round_to_single(hs, h - l, eh - k);
    if (l > h) return round_to_single(ls, l - h, eh - k);
    return 32'h0;
  endfunction

  function automatic logic [31:0] add_f(logic [31:0] a, logic [31:0] b);
    return fused_mac(a, ONE_BITS, b);
  endfunction

  function automatic logic [31:0] sub_f(logic [31:0] a, logic [31:0] b);
    return fused_mac(a, ONE_BITS, b ^ 32'h8000_0000);
  endfunction

  // NaN-skipping max, +0 beats -0
  function automatic logic [31:0] max_f(logic [31:0] a, logic [31:0] b);
    bit na, nb;
    logic [31:0] ka, kb;
    na = (a[30:0] > 31'h7F80_0000);
    nb = (b[30:0] > 31'h7F80_0000);
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    if (na && nb) return QNAN_BITS;
    if (na) return b;
    if (nb) return a;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return a & b;
    return (kb > ka) ? b : a;
  endfunction

  // Fold one beat into the lane sums; reduce on the last beat
  task automatic advance_lanes(input vec_beat_t b, output bit emit, output logic [31:0] pred);
    int n;
    logic [31:0] dd, lo, hi;
    n = (b.cnt > 3'd4) ? 4 : int'(b.cnt);
    for (int i = 0; i < n; i++) begin
      case (cur_mode)
        MODE_L2SQR: begin
          dd = sub_f(b.xs[i], b.ys[i]);
          lane_acc[i] = fused_mac(dd, dd, lane_acc[i]);
        end
        MODE_L1:   lane_acc[i] = add_f(lane_acc[i], sub_f(b.xs[i], b.ys[i]) & 32'h7FFF_FFFF);
        MODE_LINF: lane_acc[i] = max_f(lane_acc[i], sub_f(b.xs[i], b.ys[i]) & 32'h7FFF_FFFF);
        MODE_NORM: lane_acc[i] = fused_mac(b.xs[i], b.xs[i], lane_acc[i]);
        default:   lane_acc[i] = fused_mac(b.xs[i], b.ys[i], lane_acc[i]);
      endcase
    end
    emit = b.last;
    pred = '0;
    if (b.last) begin
      if (cur_mode == MODE_LINF) begin
        lo = max_f(lane_acc[0], lane_acc[1]);
        hi = max_f(lane_acc[2], lane_acc[3]);
        pred = max_f(lo, hi);
      end else begin
        lo = add_f(lane_acc[0], lane_acc[1]);
        hi = add_f(lane_acc[2], lane_acc[3]);
        pred = add_f(lo, hi);
      end
      for (int i = 0; i < 4; i++) lane_acc[i] = ZERO_BITS;
    end
  endtask

  // Offer one beat; gaps come between bursts unless the output is held off
  task automatic send_beat(input vec_beat_t b, input bit typed, input logic [31:0] want);
    bit emit;
    logic [31:0] pred;
    int gap;
    @(negedge clk);
    x_elem0 = b.xs[0]; x_elem1 = b.xs[1]; x_elem2 = b.xs[2]; x_elem3 = b.xs[3];
    y_elem0 = b.ys[0]; y_elem1 = b.ys[1]; y_elem2 = b.ys[2]; y_elem3 = b.ys[3];
    valid_count = b.cnt;
    last_item = b.last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    beats_in++;
    advance_lanes(b, emit, pred);
    if (emit) dist_q.push_back(typed ? want : pred);
    gap = 0;
    if (burst_left > 0) burst_left--;
    else if (!hold_req) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and let every pending distance come out
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [2:0] mode);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = MODE_ADDR; pwdata = {29'd0, mode}; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    cur_mode = mode;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic logic [31:0] rand_float();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 7))
        0: return ZERO_BITS;
        1: return F_NZERO;
        2: return F_PINF;
        3: return F_PINF | 32'h8000_0000;
        4: return $urandom | 32'h7F80_0001;
        5: return F_MAXN | {1'($urandom_range(0, 1)), 31'd0};
        6: return {1'($urandom_range(0, 1)), 8'd0, 23'($urandom)};
        default: return ONE_BITS;
      endcase
    end
    if (r < 40) return $urandom;
    return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
  endfunction

  // Receiver: randomly re-picked ready pattern, plus one long hold
  initial begin
    int pat, cyc, stall;
    pat = 0; cyc = 0; stall = 0; holding = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 50 == 0) pat = $urandom_range(0, 3);
      if (hold_req && !holding) begin
        holding = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        out_ready = 1'b0;
      end else begin
        case (pat)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom);
          2: out_ready = ($urandom_range(0, 7) != 0);
          default: out_ready = ((cyc / 5) % 2 == 0);
        endcase
      end
    end
  end

  // Check each distance beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      dists_out++;
      if (dist_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected distance beat, actual %h", $time, distance_bits);
      end else if (distance_bits !== dist_q[0]) begin
        errors++;
        $display("%0t: distance mismatch, expected %h actual %h", $time, dist_q[0],
                 distance_bits);
        void'(dist_q.pop_front());
      end else begin
        void'(dist_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || rst || psel) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    vec_beat_t b;
    logic [2:0] phase_modes[16];
    int vlen;
    cur_mode = MODE_DOT;
    for (int i = 0; i < 4; i++) lane_acc[i] = ZERO_BITS;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows: typed results where the value is obvious
    rows = '{
      '{MODE_DOT,   ONE_BITS, F_TWO,    3'd1, 1'b1, 1'b1, F_TWO},
      '{MODE_DOT,   ONE_BITS, F_TWO,    3'd4, 1'b1, 1'b1, 32'h4100_0000},
      '{MODE_DOT,   F_SNAN,   ONE_BITS, 3'd4, 1'b1, 1'b1, QNAN_BITS},
      '{MODE_DOT,   F_PINF,   ZERO_BITS,3'd1, 1'b1, 1'b1, QNAN_BITS},
      '{MODE_DOT,   F_MAXN,   F_MAXN,   3'd1, 1'b1, 1'b1, F_PINF},
      '{MODE_DOT,   ONE_BITS, ONE_BITS, 3'd0, 1'b1, 1'b1, ZERO_BITS},
      '{MODE_DOT,   ONE_BITS, ONE_BITS, 3'd7, 1'b1, 1'b1, 32'h4080_0000},
      '{MODE_DOT,   F_NZERO,  ZERO_BITS,3'd4, 1'b1, 1'b1, ZERO_BITS},
      '{MODE_DOT,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, QNAN_BITS},
      '{MODE_DOT,   F_MAXN,   F_MAXN ^ 32'h8000_0000, 3'd4, 1'b0, 1'b0, 32'h0},
      '{MODE_DOT,   F_TINY,   32'h0080_0000, 3'd4, 1'b1, 1'b0, 32'h0},
      '{MODE_L2SQR, F_THREE,  ONE_BITS, 3'd4, 1'b1, 1'b1, 32'h4180_0000},
      '{MODE_L2SQR, F_FIVE,   F_NTWO,   3'd3, 1'b0, 1'b0, 32'h0},
      '{MODE_LINF,  F_FIVE,   ONE_BITS, 3'd4, 1'b1, 1'b0, 32'h0},
      '{MODE_L1,    ONE_BITS, F_NTWO,   3'd2, 1'b1, 1'b1, 32'h40C0_0000},
      '{MODE_LINF,  ONE_BITS, F_FIVE,   3'd4, 1'b1, 1'b1, 32'h4080_0000},
      '{MODE_LINF,  F_SNAN,   ONE_BITS, 3'd4, 1'b1, 1'b1, ZERO_BITS},
      '{MODE_LINF,  F_NZERO,  F_NZERO,  3'd4, 1'b1, 1'b1, ZERO_BITS},
      '{MODE_NORM,  F_TWO,    F_SNAN,   3'd4, 1'b1, 1'b1, 32'h4180_0000},
      '{MODE_SPARE5, ONE_BITS, F_THREE, 3'd1, 1'b1, 1'b1, F_THREE},
      '{MODE_SPARE7, F_TINY,  F_TINY,   3'd4, 1'b1, 1'b1, ZERO_BITS},
      '{MODE_SPARE6, F_MAXN,  F_PINF,   3'd4, 1'b1, 1'b1, F_PINF}
    };
    foreach (rows[r]) begin
      // the L2-then-LINF pair switches metric in the middle of a vector
      if (rows[r].mode != cur_mode) begin
        wait_idle();
        set_mode(rows[r].mode);
      end
      for (int i = 0; i < 4; i++) begin
        b.xs[i] = rows[r].xv;
        b.ys[i] = rows[r].yv;
      end
      b.cnt = rows[r].cnt;
      b.last = rows[r].last;
      send_beat(b, rows[r].typed, rows[r].want);
    end

    // random phases, one metric each, extremes of the mode range included
    phase_modes = '{MODE_DOT, MODE_L2SQR, MODE_L1, MODE_LINF, MODE_NORM, MODE_SPARE5,
                    MODE_SPARE6, MODE_SPARE7, MODE_LINF, MODE_L2SQR, MODE_L1, MODE_DOT,
                    MODE_NORM, MODE_LINF, MODE_L2SQR, MODE_L1};
    foreach (phase_modes[ph]) begin
      wait_idle();
      set_mode(phase_modes[ph]);
      if (ph == 2) hold_req = 1'b1;
      vlen = 0;
      for (int n = 0; n < 60; n++) begin
        if (vlen == 0) vlen = (ph == 2) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        vlen--;
        for (int i = 0; i < 4; i++) begin
          b.xs[i] = rand_float();
          b.ys[i] = rand_float();
        end
        if ($urandom_range(0, 9) == 0) b.cnt = 3'($urandom_range(0, 7));
        else b.cnt = ($urandom_range(0, 1) == 0) ? 3'd4 : 3'($urandom_range(1, 3));
        b.last = (vlen == 0);
        if ($urandom_range(0, 19) == 0) b.last = ~b.last;
        send_beat(b, 1'b0, 32'h0);
      end
      if (ph == 2) hold_req = 1'b0;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Covered %0d input beats and %0d distances over all eight metric codes,",
             beats_in, dists_out);
    $display("with specials, lane counts 0..7, bursty input and a long output hold.");
    if (errors == 0 && dist_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/fved_pkg.sv
hdl/fved_lane.sv
hdl/fved_reduce.sv
hdl/float_vector_distance_engine_core.sv
test/tb.sv
